/* src/sba_pkg.sv */
package sba_pkg;

  localparam int NUM_CLASSES = 9;
  localparam int MAX_PAGES   = 16;
  localparam int PAGE_BYTES  = 4096;
  localparam int BPP_MAX     = PAGE_BYTES / 64;
  localparam int CLASS_BYTES = MAX_PAGES * BPP_MAX;
  localparam int MEM_DEPTH   = NUM_CLASSES * CLASS_BYTES;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int CLS_W       = 4;
  localparam int PG_W        = $clog2(MAX_PAGES);
  localparam int PC_W        = $clog2(MAX_PAGES + 1);
  localparam int BYTE_W      = $clog2(CLASS_BYTES);
  localparam int CNT_W       = 14;
  localparam int PB_DEPTH    = NUM_CLASSES * MAX_PAGES;
  localparam int PB_AW       = $clog2(PB_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_PAGES  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DBL_FREE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AREAD, S_AWAIT, S_ACHECK, S_ABASE, S_AWRITE,
    S_FREAD, S_FWAIT, S_FCHECK, S_FBREAD, S_FBWAIT, S_FBWRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } bm_req_t;

  function automatic logic [9:0] objs_per_page(input logic [CLS_W-1:0] c);
    return 10'(PAGE_BYTES >> (3 + c));
  endfunction

  function automatic logic [6:0] bytes_per_page(input logic [CLS_W-1:0] c);
    logic [9:0] n;
    n = objs_per_page(c);
    return (n[9:3] == 7'd0) ? 7'd1 : n[9:3];
  endfunction

  function automatic logic [7:0] reset_fill(input logic [CLS_W-1:0] c);
    logic [9:0] n;
    n = objs_per_page(c);
    return (n < 10'd8) ? 8'(8'hFF << n[3:0]) : 8'h00;
  endfunction

  function automatic logic [MEM_AW-1:0] class_off(input logic [CLS_W-1:0] c);
    return MEM_AW'(c * CLASS_BYTES);
  endfunction

endpackage

/* src/sba_bitmap_mem.sv */
module sba_bitmap_mem (
  input  logic                   clk,
  input  sba_pkg::bm_req_t       req,
  output logic [7:0]             rdata
);
  logic [7:0] mem_r [sba_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem_r[req.addr] <= req.wdata;
    rdata <= mem_r[req.addr];
  end
endmodule

/* src/sba_ctrl.sv */
module sba_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic         in_func,
  input  logic [11:0]  in_request_size,
  input  logic [31:0]  in_new_page_base,
  input  logic [31:0]  in_free_address,
  output logic         out_valid,
  output logic [31:0]  out_result_address,
  output logic [2:0]   out_status,
  output logic         out_took_page,
  output logic [3:0]   out_size_class,
  output logic [3:0]   out_page_index,
  output logic [8:0]   out_slot_index,
  output logic [13:0]  out_used_objects,
  output logic [13:0]  out_free_objects
);
  localparam int AW = sba_pkg::MEM_AW;
  localparam int CW = sba_pkg::CLS_W;
  localparam int PW = sba_pkg::PG_W;
  localparam int BW = sba_pkg::BYTE_W;
  localparam int NW = sba_pkg::CNT_W;

  sba_pkg::state_t state_r, state_nxt;
  sba_pkg::bm_req_t req;
  logic [7:0] rdata;

  sba_bitmap_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  logic [19:0] pbt_r [sba_pkg::PB_DEPTH];
  logic [19:0] pb_rd_r;
  logic [sba_pkg::PB_AW-1:0] pb_addr;
  logic pb_we;
  logic [19:0] pb_wdata;

  logic [sba_pkg::PC_W-1:0] pcnt_r [sba_pkg::NUM_CLASSES];
  logic [NW-1:0] fcnt_r [sba_pkg::NUM_CLASSES];
  logic [NW-1:0] ucnt_r [sba_pkg::NUM_CLASSES];

  logic [AW-1:0] clr_r;
  logic [CW-1:0] cls_r;
  logic [sba_pkg::PC_W-1:0] pg_r;
  logic [BW-1:0] byte_r;
  logic [6:0]    bip_r;     // byte within page
  logic [7:0]    val_r;
  logic [8:0]    slot_r;
  logic [31:0]   fa_r;
  logic [2:0]    bit_r;

  logic [31:0] res_addr_r;
  logic [2:0]  res_st_r;
  logic        res_took_r, res_show_r, res_cnt_r, out_v_r;

  logic [CW-1:0] req_cls;
  logic [2:0]    low_clear;
  logic [6:0]    bpp;
  logic [9:0]    opp;
  logic [31:0]   base;
  logic [32:0]   hi, diff;
  logic [8:0]    fslot;
  logic          in_range;
  logic          clr_last;
  logic [sba_pkg::PC_W-1:0] pc_cur;
  logic          alloc_ok, new_pg, no_pg, scan_end;
  logic [2:0]    st_start;

  always_comb begin
    req_cls = CW'(sba_pkg::NUM_CLASSES);
    for (int i = sba_pkg::NUM_CLASSES - 1; i >= 0; i--)
      if ({1'b0, in_request_size} <= 13'(8 << i)) req_cls = CW'(i);
    alloc_ok = !in_func && (req_cls < CW'(sba_pkg::NUM_CLASSES));
    new_pg = start && alloc_ok && (fcnt_r[req_cls] == '0)
             && (pcnt_r[req_cls] < sba_pkg::PC_W'(sba_pkg::MAX_PAGES));
    no_pg = alloc_ok && (fcnt_r[req_cls] == '0)
            && (pcnt_r[req_cls] >= sba_pkg::PC_W'(sba_pkg::MAX_PAGES));
    if (in_func) st_start = sba_pkg::ST_OK;
    else if (!alloc_ok) st_start = sba_pkg::ST_TOO_LARGE;
    else if (no_pg) st_start = sba_pkg::ST_NO_PAGES;
    else st_start = sba_pkg::ST_OK;
    low_clear = 3'd0;
    for (int i = 7; i >= 0; i--)
      if (!rdata[i]) low_clear = 3'(i);
    bpp = sba_pkg::bytes_per_page(cls_r);
    opp = sba_pkg::objs_per_page(cls_r);
    pc_cur = pcnt_r[cls_r];
    scan_end = (11'(byte_r) + 11'd1) >= 11'(pc_cur * bpp);
    base = {pb_rd_r, 12'd0};
    hi = {1'b0, base} + 33'(({22'd0, opp} - 32'd1) << (3 + cls_r));
    diff = {1'b0, fa_r} - {1'b0, base};
    fslot = 9'(diff >> (3 + cls_r));
    in_range = ({1'b0, fa_r} >= {1'b0, base}) && ({1'b0, fa_r} <= hi);
    clr_last = (clr_r == AW'(sba_pkg::MEM_DEPTH - 1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sba_pkg::S_CLEAR: if (clr_last) state_nxt = sba_pkg::S_IDLE;
      sba_pkg::S_IDLE: begin
        if (start) begin
          if (in_func) state_nxt = sba_pkg::S_FREAD;
          else if (req_cls >= CW'(sba_pkg::NUM_CLASSES)) state_nxt = sba_pkg::S_DONE;
          else if (fcnt_r[req_cls] == '0) state_nxt = sba_pkg::S_DONE;
          else state_nxt = sba_pkg::S_AREAD;
        end
      end
      sba_pkg::S_AREAD:  state_nxt = sba_pkg::S_AWAIT;
      sba_pkg::S_AWAIT:  state_nxt = sba_pkg::S_ACHECK;
      sba_pkg::S_ACHECK: begin
        if (rdata != 8'hFF) state_nxt = sba_pkg::S_ABASE;
        else if (scan_end) state_nxt = sba_pkg::S_DONE;
        else state_nxt = sba_pkg::S_AREAD;
      end
      sba_pkg::S_ABASE:  state_nxt = sba_pkg::S_AWRITE;
      sba_pkg::S_AWRITE: state_nxt = sba_pkg::S_DONE;
      sba_pkg::S_FREAD:  begin
        if (pg_r >= pc_cur) begin
          if (cls_r == CW'(sba_pkg::NUM_CLASSES - 1)) state_nxt = sba_pkg::S_DONE;
          else state_nxt = sba_pkg::S_FREAD;
        end else state_nxt = sba_pkg::S_FWAIT;
      end
      sba_pkg::S_FWAIT:  state_nxt = sba_pkg::S_FCHECK;
      sba_pkg::S_FCHECK: state_nxt = in_range ? sba_pkg::S_FBREAD : sba_pkg::S_FREAD;
      sba_pkg::S_FBREAD: state_nxt = sba_pkg::S_FBWAIT;
      sba_pkg::S_FBWAIT: state_nxt = sba_pkg::S_FBWRITE;
      sba_pkg::S_FBWRITE: state_nxt = sba_pkg::S_DONE;
      sba_pkg::S_DONE:   state_nxt = sba_pkg::S_IDLE;
      default:           state_nxt = sba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.we = 1'b0;
    req.addr = sba_pkg::class_off(cls_r) + AW'(byte_r);
    req.wdata = rdata;
    pb_we = 1'b0;
    pb_addr = sba_pkg::PB_AW'(cls_r * sba_pkg::MAX_PAGES + pg_r);
    pb_wdata = in_new_page_base[31:12];
    case (state_r)
      sba_pkg::S_CLEAR: begin
        req.we = 1'b1;
        req.addr = clr_r;
        req.wdata = sba_pkg::reset_fill(CW'(clr_r / sba_pkg::CLASS_BYTES));
      end
      sba_pkg::S_IDLE: begin
        // record the new page's frame on the accepting edge
        pb_we = new_pg;
        pb_addr = sba_pkg::PB_AW'(req_cls * sba_pkg::MAX_PAGES)
                  + sba_pkg::PB_AW'(pcnt_r[req_cls]);
      end
      sba_pkg::S_AWRITE: begin
        req.we = 1'b1;
        req.wdata = val_r | 8'(8'd1 << bit_r);
      end
      sba_pkg::S_FBWRITE: begin
        req.we = rdata[bit_r];
        req.wdata = rdata & ~8'(8'd1 << bit_r);
      end
      sba_pkg::S_DONE: begin
        // new page: its first byte still holds the reset fill, set bit 0
        req.we = res_took_r;
        req.wdata = sba_pkg::reset_fill(cls_r) | 8'h01;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pb_we) pbt_r[pb_addr] <= pb_wdata;
    pb_rd_r <= pbt_r[pb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sba_pkg::S_CLEAR;
      clr_r <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < sba_pkg::NUM_CLASSES; i++) begin
        pcnt_r[i] <= '0; fcnt_r[i] <= '0; ucnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_v_r <= (state_r == sba_pkg::S_DONE);
      if (state_r == sba_pkg::S_CLEAR) clr_r <= clr_r + AW'(1);
      case (state_r)
        sba_pkg::S_IDLE: begin
          if (start) begin
            res_addr_r <= new_pg ? {in_new_page_base[31:12], 12'd0} : '0;
            res_took_r <= new_pg;
            res_show_r <= new_pg;
            res_cnt_r <= alloc_ok;
            res_st_r <= st_start;
            bip_r <= '0; slot_r <= '0;
            bit_r <= 3'd0;
            fa_r <= in_free_address;
            cls_r <= in_func ? '0 : req_cls;
            pg_r <= new_pg ? pcnt_r[req_cls] : '0;
            byte_r <= new_pg ?
                      BW'(PW'(pcnt_r[req_cls]) * sba_pkg::bytes_per_page(req_cls)) : '0;
            if (new_pg) begin
              pcnt_r[req_cls] <= pcnt_r[req_cls] + 1'b1;
              fcnt_r[req_cls] <= NW'(sba_pkg::objs_per_page(req_cls) - 10'd1);
              ucnt_r[req_cls] <= ucnt_r[req_cls] + NW'(1);
            end
          end
        end
        sba_pkg::S_ACHECK: begin
          if (rdata != 8'hFF) begin
            val_r <= rdata; bit_r <= low_clear;
            slot_r <= 9'({bip_r, 3'd0}) + 9'(low_clear);
          end else begin
            byte_r <= byte_r + BW'(1);
            if (bip_r == bpp - 7'd1) begin
              bip_r <= '0; pg_r <= pg_r + sba_pkg::PC_W'(1);
            end else bip_r <= bip_r + 7'd1;
            if (scan_end) res_st_r <= sba_pkg::ST_NO_PAGES;
          end
        end
        sba_pkg::S_AWRITE: begin
          res_addr_r <= base + (32'(slot_r) << (3 + cls_r));
          res_show_r <= 1'b1;
          fcnt_r[cls_r] <= fcnt_r[cls_r] - NW'(1);
          ucnt_r[cls_r] <= ucnt_r[cls_r] + NW'(1);
        end
        sba_pkg::S_FREAD: begin
          if (pg_r >= pc_cur) begin
            pg_r <= '0;
            if (cls_r == CW'(sba_pkg::NUM_CLASSES - 1)) res_st_r <= sba_pkg::ST_NOT_FOUND;
            else cls_r <= cls_r + CW'(1);
          end
        end
        sba_pkg::S_FCHECK: begin
          if (in_range) begin
            slot_r <= fslot;
            bit_r <= fslot[2:0];
            byte_r <= BW'(pg_r * bpp) + BW'(fslot[8:3]);
            res_show_r <= 1'b1; res_cnt_r <= 1'b1;
          end else pg_r <= pg_r + sba_pkg::PC_W'(1);
        end
        sba_pkg::S_FBWRITE: begin
          if (!rdata[bit_r]) res_st_r <= sba_pkg::ST_DBL_FREE;
          else begin
            fcnt_r[cls_r] <= fcnt_r[cls_r] + NW'(1);
            ucnt_r[cls_r] <= ucnt_r[cls_r] - NW'(1);
          end
        end
        default: ;
      endcase
      if (state_r == sba_pkg::S_DONE) begin
        out_result_address <= res_addr_r;
        out_status <= res_st_r;
        out_took_page <= res_took_r;
        out_size_class <= res_cnt_r ? cls_r : '0;
        out_page_index <= res_show_r ? 4'(pg_r) : '0;
        out_slot_index <= (res_show_r && !res_took_r) ? slot_r : '0;
        out_used_objects <= res_cnt_r ? ucnt_r[cls_r] : '0;
        out_free_objects <= res_cnt_r ? fcnt_r[cls_r] : '0;
      end
    end
  end

  assign busy = (state_r != sba_pkg::S_IDLE);
  assign out_valid = out_v_r;
endmodule

/* src/slab_bitmap_allocator.sv */
// Slab allocator: nine power-of-two size classes (8..2048 bytes) over
// 4096-byte pages, up to 16 pages per class, one bitmap bit per object.
// Usage: present in_* fields and raise start while busy is low; the item is
// taken on that edge. One result follows, shown on out_* for exactly one
// cycle with out_valid high; the receiver cannot stall it.
// An allocate from a class with free objects scans the bitmap bytes in
// order, each through a read, a wait and a check state, and sets the first
// clear bit it finds; a class with no free object installs in_new_page_base
// while it holds fewer than 16 pages, else answers ST_NO_PAGES, no scan.
// A free item steps through the classes and checks each installed page's
// range (read, wait, check), then reads, waits on and writes the bitmap byte;
// busy drops with out_valid. The shared bitmap memory port and the range
// compare set these steps. After reset the block sweeps the 9216-byte bitmap
// memory, one byte a cycle, holding busy high; all counts reset to zero.
module slab_bitmap_allocator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic         in_func,
  input  logic [11:0]  in_request_size,
  input  logic [31:0]  in_new_page_base,
  input  logic [31:0]  in_free_address,
  output logic         out_valid,
  output logic [31:0]  out_result_address,
  output logic [2:0]   out_status,
  output logic         out_took_page,
  output logic [3:0]   out_size_class,
  output logic [3:0]   out_page_index,
  output logic [8:0]   out_slot_index,
  output logic [13:0]  out_used_objects,
  output logic [13:0]  out_free_objects
);
  sba_ctrl u_ctrl (.*);
endmodule

/* sim/slab_bitmap_allocator_tb.sv */
`timescale 1ns / 100ps

module slab_bitmap_allocator_tb;

  localparam int  CPB       = sba_pkg::PAGE_BYTES / 64 * sba_pkg::MAX_PAGES;
  localparam longint LIMIT  = 20_000_000;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
    logic        took;
    logic [3:0]  cls;
    logic [3:0]  pg;
    logic [8:0]  slot;
    logic [13:0] used;
    logic [13:0] free;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [11:0] in_request_size;
  logic [31:0] in_new_page_base;
  logic [31:0] in_free_address;
  logic        out_valid;
  logic [31:0] out_result_address;
  logic [2:0]  out_status;
  logic        out_took_page;
  logic [3:0]  out_size_class;
  logic [3:0]  out_page_index;
  logic [8:0]  out_slot_index;
  logic [13:0] out_used_objects;
  logic [13:0] out_free_objects;

  // shadow of the allocator state
  logic [7:0]  bitmap_mirror [sba_pkg::NUM_CLASSES][CPB];
  logic [19:0] page_frame    [sba_pkg::NUM_CLASSES][sba_pkg::MAX_PAGES];
  int unsigned pages_in      [sba_pkg::NUM_CLASSES];
  int unsigned free_in       [sba_pkg::NUM_CLASSES];
  int unsigned used_in       [sba_pkg::NUM_CLASSES];

  alloc_result_t pending_results[$];
  logic [31:0]   live_objects[$];
  logic [31:0]   freed_objects[$];
  int            errors;
  int            items_sent;
  int            results_seen;
  int            sender_idle_pct;
  longint        cycle_count;

  slab_bitmap_allocator uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned slots_per_page(int unsigned c);
    return 512 >> c;
  endfunction

  function automatic int unsigned map_bytes(int unsigned c);
    return (c <= 6) ? (64 >> c) : 1;
  endfunction

  function automatic void clear_mirror();
    for (int c = 0; c < sba_pkg::NUM_CLASSES; c++) begin
      for (int b = 0; b < CPB; b++)
        bitmap_mirror[c][b] = (c == 7) ? 8'hF0 : (c == 8) ? 8'hFC : 8'h00;
      pages_in[c] = 0;
      free_in[c]  = 0;
      used_in[c]  = 0;
    end
  endfunction

  function automatic alloc_result_t predict_step(logic func, logic [11:0] req,
                                                 logic [31:0] npb, logic [31:0] fa);
    alloc_result_t r;
    int unsigned   c, bpp, n, e, bit_i, slot;
    longint        base, hi;
    r = '0;
    if (func == 1'b0) begin
      c = 0;
      while (c < sba_pkg::NUM_CLASSES && req > (8 << c)) c++;
      if (c >= sba_pkg::NUM_CLASSES) begin
        r.status = sba_pkg::ST_TOO_LARGE;
        return r;
      end
      bpp = map_bytes(c);
      n   = slots_per_page(c);
      r.cls = c;
      if (free_in[c] == 0) begin
        e = pages_in[c];
        if (e >= sba_pkg::MAX_PAGES) begin
          r.status = sba_pkg::ST_NO_PAGES;
        end else begin
          page_frame[c][e] = npb[31:12];
          pages_in[c] = e + 1;
          bitmap_mirror[c][e * bpp][0] = 1'b1;
          free_in[c] = n - 1;
          used_in[c]++;
          r.addr = {npb[31:12], 12'h000};
          r.took = 1'b1;
          r.pg   = e;
        end
      end else begin
        r.status = sba_pkg::ST_NO_PAGES;
        for (int b = 0; b < pages_in[c] * bpp; b++) begin
          if (bitmap_mirror[c][b] != 8'hFF) begin
            bit_i = 0;
            while (bitmap_mirror[c][b][bit_i]) bit_i++;
            bitmap_mirror[c][b][bit_i] = 1'b1;
            free_in[c]--;
            used_in[c]++;
            slot = (b % bpp) * 8 + bit_i;
            r.status = sba_pkg::ST_OK;
            r.pg   = b / bpp;
            r.slot = slot;
            r.addr = {page_frame[c][b / bpp], 12'h000} + (slot << (3 + c));
            break;
          end
        end
      end
      r.used = used_in[c];
      r.free = free_in[c];
      return r;
    end
    for (c = 0; c < sba_pkg::NUM_CLASSES; c++) begin
      n = slots_per_page(c);
      bpp = map_bytes(c);
      for (int p = 0; p < pages_in[c]; p++) begin
        base = longint'(page_frame[c][p]) << 12;
        hi   = base + longint'(n - 1) * longint'(8 << c);
        if (longint'(fa) >= base && longint'(fa) <= hi) begin
          slot = (longint'(fa) - base) >> (3 + c);
          r.cls  = c;
          r.pg   = p;
          r.slot = slot;
          if (!bitmap_mirror[c][p * bpp + slot / 8][slot % 8]) begin
            r.status = sba_pkg::ST_DBL_FREE;
          end else begin
            bitmap_mirror[c][p * bpp + slot / 8][slot % 8] = 1'b0;
            free_in[c]++;
            used_in[c]--;
          end
          r.used = used_in[c];
          r.free = free_in[c];
          return r;
        end
      end
    end
    r.status = sba_pkg::ST_NOT_FOUND;
    return r;
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(logic func, logic [11:0] req, logic [31:0] npb, logic [31:0] fa);
    alloc_result_t r;
    @(negedge clk);
    in_func          = func;
    in_request_size  = req;
    in_new_page_base = npb;
    in_free_address  = fa;
    start            = 1'b1;
    do @(posedge clk); while (busy);
    r = predict_step(func, req, npb, fa);
    pending_results.push_back(r);
    items_sent++;
    if (func == 1'b0 && r.status == sba_pkg::ST_OK) live_objects.push_back(r.addr);
    if (func == 1'b1 && r.status == sba_pkg::ST_OK) freed_objects.push_back(fa);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  task automatic alloc_item(logic [11:0] req);
    send_item(1'b0, req, $urandom, $urandom);
  endtask

  task automatic free_item(logic [31:0] fa);
    send_item(1'b1, $urandom, $urandom, fa);
  endtask

  task automatic free_live(bit misalign);
    int          k;
    logic [31:0] a;
    k = $urandom_range(live_objects.size() - 1);
    a = live_objects[k];
    live_objects.delete(k);
    free_item(misalign ? a + $urandom_range(7) : a);
  endtask

  task automatic chk(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, address %0h status %0d",
                 $time, out_result_address, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        chk("result_address", e.addr, out_result_address);
        chk("status", e.status, out_status);
        chk("took_page", e.took, out_took_page);
        chk("size_class", e.cls, out_size_class);
        chk("page_index", e.pg, out_page_index);
        chk("slot_index", e.slot, out_slot_index);
        chk("used_objects", e.used, out_used_objects);
        chk("free_objects", e.free, out_free_objects);
      end
    end
  end

  task automatic test_directed();
    alloc_item(12'd0);
    alloc_item(12'd8);
    alloc_item(12'd9);
    alloc_item(12'd2048);
    alloc_item(12'd2049);
    alloc_item(12'hFFF);
    send_item(1'b0, 12'd16, 32'hFFFF_FABC, 32'h0);
    free_item(32'hFFFF_FFFF);
    free_item(32'hFFFF_FFFF);
    free_item(32'h0000_0000);
    send_item(1'b0, 12'd100, 32'h0000_0000, 32'h0);
    free_item(32'h0000_0005);
    free_item(32'h0000_0005);
    send_item(1'b0, 12'd1000, 32'hAAAA_A000, 32'h0);
    send_item(1'b0, 12'd500, 32'hAAAA_A000, 32'h0);
    free_item(32'hAAAA_A3FF);
    free_item(32'hAAAA_AC00);
    free_item(32'hAAAA_AFFF);
  endtask

  task automatic test_out_of_pages();
    for (int i = 0; i < 2 * sba_pkg::MAX_PAGES + 2; i++) alloc_item(12'd2000);
    free_live(1'b1);
    alloc_item(12'd1500);
    alloc_item(12'd1500);
  endtask

  task automatic test_random(int count, int idle_pct);
    int pick;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50)
        alloc_item($urandom_range(1) ? $urandom_range(64) : $urandom_range(2048));
      else if (pick < 54)
        alloc_item($urandom_range(4095, 2049));
      else if (pick < 88 && live_objects.size() > 0)
        free_live($urandom_range(3) == 0);
      else if (pick < 94 && freed_objects.size() > 0)
        free_item(freed_objects[$urandom_range(freed_objects.size() - 1)]);
      else
        free_item($urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = 1'b0;
    in_request_size = '0;
    in_new_page_base = '0;
    in_free_address = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    sender_idle_pct = 0;
    cycle_count = 0;
    clear_mirror();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_out_of_pages();
    test_random(350, 0);
    test_random(350, 80);
    test_random(350, 0);
    test_random(350, 20);

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d allocate/free items, checked %0d results", items_sent, results_seen);
    $display("Covered class limits, page exhaustion, double and misaligned frees");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
